FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/mapu_pkg.sv
`default_nettype none
package mapu_pkg;

   localparam int MOD_W       = 31;
   localparam int RAW_W       = 64;
   localparam int EXP_W       = 63;
   localparam int CMD_W       = 3;
   localparam int EXP_BITS_DEF = 63;
   localparam logic [MOD_W-1:0] MOD_RESET = 31'd998244353;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 3'd0,
      CMD_SUB    = 3'd1,
      CMD_MUL    = 3'd2,
      CMD_DIV    = 3'd3,
      CMD_POW    = 3'd4,
      CMD_INV    = 3'd5,
      CMD_NEG    = 3'd6,
      CMD_REDUCE = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_RAW,
      ST_PMUL,
      ST_PSQR,
      ST_FMUL,
      ST_OUT
   } state_type;

   // status of a serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage
`default_nettype wire

FILE: rtl/mapu_modmul.sv
`default_nettype none
// Bit-serial interleaved modular multiplier: one bit of y per cycle, MSB first
module mapu_modmul #(
   parameter int W = mapu_pkg::MOD_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [W-1:0]          x,
   input  wire logic [W-1:0]          y,
   input  wire logic [W-1:0]          m,
   output mapu_pkg::unit_stat_type    stat,
   output logic [W-1:0]               p
);
   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  acc_ff, acc_in;

   logic [W:0] dbl, dred, sum, sred;

   // one step: acc = 2*acc + bit*x, each folded once
   always_comb begin
      dbl  = {acc_ff, 1'b0};
      dred = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum  = dred + (y_ff[W-1] ? {1'b0, x_ff} : {(W+1){1'b0}});
      sred = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = x;
         y_in    = y;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = sred[W-1:0];
         y_in   = {y_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign p         = acc_ff;
endmodule
`default_nettype wire

FILE: rtl/mapu_modred.sv
`default_nettype none
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first
module mapu_modred #(
   parameter int N = mapu_pkg::RAW_W,
   parameter int W = mapu_pkg::MOD_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [N-1:0]          din,
   input  wire logic [W-1:0]          m,
   output mapu_pkg::unit_stat_type    stat,
   output logic [W-1:0]               rem
);
   localparam int CW = (N > 1) ? $clog2(N) : 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  v_ff, v_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W:0]    t, tr;

   always_comb begin
      t  = {rem_ff, v_ff[N-1]};
      tr = (t >= {1'b0, m}) ? t - {1'b0, m} : t;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      rem_in  = rem_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = din;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = tr[W-1:0];
         v_in   = {v_ff[N-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(N-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign rem       = rem_ff;
endmodule
`default_nettype wire

FILE: rtl/modular_arith_pow_unit.sv
`default_nettype none
// Channel  | Ports                                       | Beat
// req      | req_valid, req_stall, req_cmd .. req_raw_*  | one command
// rsp      | rsp_valid, rsp_stall, rsp_result            | one residue
// csr      | csr_psel .. csr_prdata, csr_pready          | modulus write/read
// One command at a time; req_stall is high from acceptance until the result beat leaves.
// Add, sub, negate, inverse of zero, divide by zero: two 64-step reductions.
// Mul: both reductions and a multiply; reduce: one reduction; modulus below two: straight out.
// Pow, inverse: both reductions, then per EXP_BITS bit a square, plus a multiply if set.
// Divide adds a final multiply; rsp_stall holds the result beat until it is taken.
// Synchronous reset restores the modulus to 998244353 and returns to idle.
`include "assert_macros.svh"
module modular_arith_pow_unit #(
   parameter int EXP_BITS = mapu_pkg::EXP_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [mapu_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [mapu_pkg::MOD_W-1:0]   req_operand_a,
   input  wire logic [mapu_pkg::MOD_W-1:0]   req_operand_b,
   input  wire logic [mapu_pkg::EXP_W-1:0]   req_exponent,
   input  wire logic signed [mapu_pkg::RAW_W-1:0] req_raw_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [mapu_pkg::MOD_W-1:0]        rsp_result,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [2:0]                   csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   localparam int W  = mapu_pkg::MOD_W;
   localparam int N  = mapu_pkg::RAW_W;
   localparam int CW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

   mapu_pkg::state_type state_ff, state_in;
   mapu_pkg::cmd_type   cmd_ff, cmd_in;
   logic [W-1:0]        mod_ff;
   logic [W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [W-1:0]        acc_ff, acc_in, base_ff, base_in, res_ff, res_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [N-1:0]        mag_ff, mag_in;
   logic                neg_ff, neg_in;

   logic                    req_acc, cfg_wr;
   mapu_pkg::unit_stat_type mul_stat, red_stat;
   logic                    mul_start, red_start;
   logic [W-1:0]            mul_x, mul_y, mul_p, red_rem;
   logic [N-1:0]            red_din;
   logic [W:0]              add_s, sub_s;
   logic [W-1:0]            m_minus2;

   assign req_acc = req_valid && !req_stall;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 3'd0);
   assign csr_prdata = (csr_paddr == 3'd0) ? {1'b0, mod_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= mapu_pkg::MOD_RESET;
      end else if (cfg_wr) begin
         mod_ff <= csr_pwdata[W-1:0];
      end
   end

   // serial units
   mapu_modmul #(.W(W)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .x(mul_x), .y(mul_y), .m(mod_ff), .stat(mul_stat), .p(mul_p)
   );

   mapu_modred #(.N(N), .W(W)) u_red (
      .clock(clock), .reset(reset), .start(red_start),
      .din(red_din), .m(mod_ff), .stat(red_stat), .rem(red_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mapu_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (mod_ff < W'(2))
                  state_in = mapu_pkg::ST_OUT;
               else if (mapu_pkg::cmd_type'(req_cmd) == mapu_pkg::CMD_REDUCE)
                  state_in = mapu_pkg::ST_RAW;
               else
                  state_in = mapu_pkg::ST_RED_A;
            end
         end
         mapu_pkg::ST_RED_A: if (red_stat.done) state_in = mapu_pkg::ST_RED_B;
         mapu_pkg::ST_RED_B: begin
            if (red_stat.done) begin
               unique case (cmd_ff)
                  mapu_pkg::CMD_MUL: state_in = mapu_pkg::ST_FMUL;
                  mapu_pkg::CMD_POW: state_in = mapu_pkg::ST_PMUL;
                  mapu_pkg::CMD_INV:
                     state_in = (a_ff == '0) ? mapu_pkg::ST_OUT : mapu_pkg::ST_PMUL;
                  mapu_pkg::CMD_DIV:
                     state_in = (red_rem == '0) ? mapu_pkg::ST_OUT : mapu_pkg::ST_PMUL;
                  default: state_in = mapu_pkg::ST_OUT;
               endcase
            end
         end
         mapu_pkg::ST_RAW:  if (red_stat.done) state_in = mapu_pkg::ST_OUT;
         mapu_pkg::ST_PMUL: if (!exp_ff[0] || mul_stat.done) state_in = mapu_pkg::ST_PSQR;
         mapu_pkg::ST_PSQR: begin
            if (mul_stat.done) begin
               if (cnt_ff != CW'(EXP_BITS-1))
                  state_in = mapu_pkg::ST_PMUL;
               else if (cmd_ff == mapu_pkg::CMD_DIV)
                  state_in = mapu_pkg::ST_FMUL;
               else
                  state_in = mapu_pkg::ST_OUT;
            end
         end
         mapu_pkg::ST_FMUL: if (mul_stat.done) state_in = mapu_pkg::ST_OUT;
         mapu_pkg::ST_OUT:  if (!rsp_stall) state_in = mapu_pkg::ST_IDLE;
         default: state_in = mapu_pkg::ST_IDLE;
      endcase
   end

   // outputs and unit control
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      mul_start = 1'b0;
      red_start = 1'b0;
      mul_x     = base_ff;
      mul_y     = acc_ff;
      red_din   = N'(a_ff);
      unique case (state_ff)
         mapu_pkg::ST_IDLE: req_stall = 1'b0;
         mapu_pkg::ST_RED_A: red_start = !red_stat.busy && !red_stat.done;
         mapu_pkg::ST_RED_B: begin
            red_din   = N'(b_ff);
            red_start = !red_stat.busy && !red_stat.done;
         end
         mapu_pkg::ST_RAW: begin
            red_din   = mag_ff;
            red_start = !red_stat.busy && !red_stat.done;
         end
         mapu_pkg::ST_PMUL: mul_start = exp_ff[0] && !mul_stat.busy && !mul_stat.done;
         mapu_pkg::ST_PSQR: begin
            mul_y     = base_ff;
            mul_start = !mul_stat.busy && !mul_stat.done;
         end
         mapu_pkg::ST_FMUL: begin
            mul_x     = a_ff;
            mul_start = !mul_stat.busy && !mul_stat.done;
         end
         mapu_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // short ops on reduced operands (b taken straight from the reducer)
   assign add_s    = {1'b0, a_ff} + {1'b0, red_rem};
   assign sub_s    = {1'b0, a_ff} + {1'b0, mod_ff} - {1'b0, red_rem};
   assign m_minus2 = mod_ff - W'(2);

   // datapath next values
   always_comb begin
      cmd_in  = cmd_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      base_in = base_ff;
      res_in  = res_ff;
      exp_in  = exp_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      unique case (state_ff)
         mapu_pkg::ST_IDLE: begin
            if (req_acc) begin
               cmd_in = mapu_pkg::cmd_type'(req_cmd);
               a_in   = req_operand_a;
               b_in   = req_operand_b;
               exp_in = req_exponent[EXP_BITS-1:0];
               neg_in = req_raw_value[N-1];
               mag_in = req_raw_value[N-1] ? (~req_raw_value) + 1'b1 : req_raw_value;
               res_in = '0;
               cnt_in = '0;
            end
         end
         mapu_pkg::ST_RED_A: if (red_stat.done) a_in = red_rem;
         mapu_pkg::ST_RED_B: begin
            if (red_stat.done) begin
               b_in    = red_rem;
               acc_in  = W'(1);
               base_in = a_ff;
               case (cmd_ff)
                  mapu_pkg::CMD_ADD:
                     res_in = (add_s >= {1'b0, mod_ff}) ? W'(add_s - {1'b0, mod_ff})
                                                         : add_s[W-1:0];
                  mapu_pkg::CMD_SUB:
                     res_in = (a_ff >= red_rem) ? a_ff - red_rem : sub_s[W-1:0];
                  mapu_pkg::CMD_NEG:
                     res_in = (a_ff == '0) ? '0 : mod_ff - a_ff;
                  mapu_pkg::CMD_MUL: acc_in = red_rem;
                  mapu_pkg::CMD_INV: exp_in = EXP_BITS'({32'd0, m_minus2});
                  mapu_pkg::CMD_DIV: begin
                     base_in = red_rem;
                     exp_in  = EXP_BITS'({32'd0, m_minus2});
                  end
                  default: ;
               endcase
            end
         end
         mapu_pkg::ST_RAW: begin
            if (red_stat.done)
               res_in = (neg_ff && red_rem != '0) ? mod_ff - red_rem : red_rem;
         end
         mapu_pkg::ST_PMUL: if (mul_stat.done) acc_in = mul_p;
         mapu_pkg::ST_PSQR: begin
            if (mul_stat.done) begin
               base_in = mul_p;
               exp_in  = exp_ff >> 1;
               cnt_in  = cnt_ff + 1'b1;
               res_in  = acc_ff;
            end
         end
         mapu_pkg::ST_FMUL: if (mul_stat.done) res_in = mul_p;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mapu_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff  <= cmd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      res_ff  <= res_in;
      exp_ff  <= exp_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
   end

   assign rsp_result = res_ff;

   // checks
   `ASSERT_IMPL(a_units_excl, clock, reset, 1'b1, !(mul_stat.busy && red_stat.busy))
   `ASSERT_NEXT(a_acc_busy, clock, reset, req_acc, req_stall)
   `ASSERT_IMPL(a_res_range, clock, reset, rsp_valid, (res_ff < mod_ff) || (mod_ff < W'(2)))
   `ASSERT_IMPL(a_mul_owner, clock, reset, mul_stat.busy,
                state_ff == mapu_pkg::ST_PMUL || state_ff == mapu_pkg::ST_PSQR ||
                state_ff == mapu_pkg::ST_FMUL)
endmodule
`default_nettype wire
